>>> src/uxf_pkg.sv
package uxf_pkg;

    localparam int FIFO_DEPTH_DEF = 64;

    localparam logic [7:0] STOP_CHAR_RST   = 8'h13;
    localparam logic [7:0] RESUME_CHAR_RST = 8'h11;

    // configuration register indexes
    localparam logic REG_STOP   = 1'b0;
    localparam logic REG_RESUME = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_READ     = 2'd1,
        KIND_TX_READY = 2'd2,
        KIND_RX       = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_WRITE_FULL  = 2'd1,
        STAT_READ_EMPTY  = 2'd2,
        STAT_RX_DROP     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FLOW_QUIET     = 3'b001,
        FLOW_SENDING   = 3'b010,
        FLOW_THROTTLED = 3'b100
    } flow_t;

    localparam logic [1:0] MODE_QUIET     = 2'd0;
    localparam logic [1:0] MODE_SENDING   = 2'd1;
    localparam logic [1:0] MODE_THROTTLED = 2'd2;

    // result word, line_valid in the lowest bit
    typedef struct packed {
        logic [1:0] pad;
        logic [1:0] flow_mode;
        status_t    status;
        logic [7:0] host_byte;
        logic       host_valid;
        logic [7:0] line_byte;
        logic       line_valid;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    function automatic logic [1:0] flow_mode(input flow_t f);
        logic [1:0] m;
        unique case (f)
            FLOW_QUIET:     m = MODE_QUIET;
            FLOW_SENDING:   m = MODE_SENDING;
            FLOW_THROTTLED: m = MODE_THROTTLED;
            default:        m = MODE_QUIET;
        endcase
        return m;
    endfunction

endpackage

>>> src/uxf_fifo.sv
module uxf_fifo #(
    parameter int DEPTH = uxf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  uxf_pkg::fifo_ctl_t    ctl,
    input  logic [7:0]            push_data,
    output logic [7:0]            head_data,
    output uxf_pkg::fifo_stat_t   stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    rdata_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (ctl.pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (ctl.push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (ctl.push && !ctl.pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (ctl.pop && !ctl.push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= push_data;
        end
    end

    // read ahead at the next head so the head word is ready every cycle
    always_ff @(posedge clk)
    begin
        if (ctl.push && (tail_reg == head_next))
        begin
            rdata_reg <= push_data;
        end
        else
        begin
            rdata_reg <= mem[head_next];
        end
    end

    assign head_data  = rdata_reg;
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CW'(DEPTH));

endmodule

>>> src/uart_xon_xoff_fifo_channel_top.sv
// Serial channel with a transmit queue, a type-ahead receive queue and XON/XOFF
// throttling of the output. Each slave word is one event (tuser = kind: host write,
// host read, transmitter ready, byte received; tdata = the byte) and yields exactly
// one master word. One event is taken per clock unless m_tready stalls the result:
// it is registered on acceptance, handled from that register against the queue
// heads and the flow state, and its result word is registered. cfg_ready is always
// high. Both queues are FIFO_DEPTH bytes deep and keep their head byte read ahead
// from memory, so a pop never waits. A full or empty queue refuses the access and
// says so in status. The user must write the stop and resume characters on the cfg
// port (index 0 stop, 1 resume) only while no event is in flight; the block does not enforce it.
module uart_xon_xoff_fifo_channel_top #(
    parameter int FIFO_DEPTH = uxf_pkg::FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data[7:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // line_valid[0], line_byte[8:1], host_valid[9], host_byte[17:10],
    // status[19:18], flow_mode[21:20], zero[23:22]
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic                in_valid_reg;
    uxf_pkg::kind_t      in_kind_reg;
    logic [7:0]          in_data_reg;
    logic                out_valid_reg;
    uxf_pkg::result_t    out_reg, out_next;
    uxf_pkg::flow_t      flow_reg, flow_next;
    logic [7:0]          stop_reg;
    logic [7:0]          resume_reg;
    logic                advance;

    uxf_pkg::fifo_ctl_t  tx_ctl, rx_ctl;
    uxf_pkg::fifo_stat_t tx_stat, rx_stat;
    logic [7:0]          tx_head, rx_head;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg   <= uxf_pkg::STOP_CHAR_RST;
            resume_reg <= uxf_pkg::RESUME_CHAR_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == uxf_pkg::REG_STOP)
            begin
                stop_reg <= cfg_data;
            end
            else
            begin
                resume_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= uxf_pkg::kind_t'(s_tuser);
            in_data_reg <= s_tdata;
        end
    end

    always_comb
    begin
        out_next            = '0;
        flow_next           = flow_reg;
        tx_ctl              = '0;
        rx_ctl              = '0;
        out_next.status     = uxf_pkg::STAT_OK;
        unique case (in_kind_reg)
            uxf_pkg::KIND_WRITE:
            begin
                if (tx_stat.full)
                begin
                    out_next.status = uxf_pkg::STAT_WRITE_FULL;
                end
                else if (flow_reg == uxf_pkg::FLOW_QUIET)
                begin
                    // quiet means the queue is empty: the byte goes straight out
                    out_next.line_valid = 1'b1;
                    out_next.line_byte  = in_data_reg;
                    flow_next           = uxf_pkg::FLOW_SENDING;
                end
                else
                begin
                    tx_ctl.push = 1'b1;
                end
            end
            uxf_pkg::KIND_READ:
            begin
                if (rx_stat.empty)
                begin
                    out_next.status = uxf_pkg::STAT_READ_EMPTY;
                end
                else
                begin
                    out_next.host_valid = 1'b1;
                    out_next.host_byte  = rx_head;
                    rx_ctl.pop          = 1'b1;
                end
            end
            uxf_pkg::KIND_TX_READY:
            begin
                if (flow_reg == uxf_pkg::FLOW_SENDING)
                begin
                    if (tx_stat.empty)
                    begin
                        flow_next = uxf_pkg::FLOW_QUIET;
                    end
                    else
                    begin
                        out_next.line_valid = 1'b1;
                        out_next.line_byte  = tx_head;
                        tx_ctl.pop          = 1'b1;
                    end
                end
            end
            uxf_pkg::KIND_RX:
            begin
                if (in_data_reg == stop_reg)
                begin
                    flow_next = uxf_pkg::FLOW_THROTTLED;
                end
                else if (in_data_reg == resume_reg)
                begin
                    if (flow_reg == uxf_pkg::FLOW_THROTTLED)
                    begin
                        if (tx_stat.empty)
                        begin
                            flow_next = uxf_pkg::FLOW_QUIET;
                        end
                        else
                        begin
                            out_next.line_valid = 1'b1;
                            out_next.line_byte  = tx_head;
                            tx_ctl.pop          = 1'b1;
                            flow_next           = uxf_pkg::FLOW_SENDING;
                        end
                    end
                end
                else if (rx_stat.full)
                begin
                    out_next.status = uxf_pkg::STAT_RX_DROP;
                end
                else
                begin
                    rx_ctl.push = 1'b1;
                end
            end
            default:
            begin
                flow_next = flow_reg;
            end
        endcase
        out_next.flow_mode = uxf_pkg::flow_mode(flow_next);
        // queues only move when the event really completes
        if (!advance)
        begin
            tx_ctl = '0;
            rx_ctl = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg      <= uxf_pkg::FLOW_QUIET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                flow_reg      <= flow_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    uxf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_tx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tx_ctl),
        .push_data (in_data_reg),
        .head_data (tx_head),
        .stat      (tx_stat)
    );

    uxf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rx_ctl),
        .push_data (in_data_reg),
        .head_data (rx_head),
        .stat      (rx_stat)
    );

endmodule

>>> src/uxf_checker.sv
module uxf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    uxf_pkg::result_t res;

    assign res = uxf_pkg::result_t'(m_tdata);

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

    // a byte only reaches the line when the channel ends up sending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.line_valid |-> res.flow_mode == uxf_pkg::MODE_SENDING)
    else $error("line byte without sending state");

    // a refused or dropped access moves no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.status != uxf_pkg::STAT_OK |-> !res.line_valid && !res.host_valid)
    else $error("byte moved on a refused access");

    // unused byte fields read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.line_valid || res.line_byte == '0)
                  && (res.host_valid || res.host_byte == '0))
    else $error("byte field not zero without its valid flag");

    // a read returns data or reports empty, nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.host_valid |-> !res.line_valid && res.status == uxf_pkg::STAT_OK)
    else $error("host read mixed with other results");

endmodule

bind uart_xon_xoff_fifo_channel_top uxf_checker u_uxf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import uxf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        bit         typed;
        result_t    want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // data[7:0]
    logic [1:0]  s_tuser = 2'd0;     // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // line_valid[0], line_byte[8:1], host_valid[9], host_byte[17:10],
    // status[19:18], flow_mode[21:20], zero[23:22]
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_STOP;
    logic [7:0]  cfg_data = 8'h00;

    // predictor state
    logic [1:0]  line_mode = MODE_QUIET;
    logic [7:0]  tx_bytes[$];
    logic [7:0]  rx_bytes[$];
    logic [7:0]  stop_char_q = STOP_CHAR_RST;
    logic [7:0]  resume_char_q = RESUME_CHAR_RST;

    result_t     due_words[$];
    script_row_t script[$];
    int          fail_count = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int unsigned ready_cnt = 0;

    uart_xon_xoff_fifo_channel_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic result_t mk_word(logic lv, logic [7:0] lb, logic hv, logic [7:0] hb,
                                        status_t st, logic [1:0] fm);
        result_t r;
        r = '0;
        r.line_valid = lv;
        r.line_byte  = lb;
        r.host_valid = hv;
        r.host_byte  = hb;
        r.status     = st;
        r.flow_mode  = fm;
        return r;
    endfunction

    // one event against the channel model, returns the result word it yields
    function automatic result_t channel_step(kind_t k, logic [7:0] d);
        result_t r;
        r = '0;
        case (k)
            KIND_WRITE:
            begin
                if (tx_bytes.size() >= FIFO_DEPTH_DEF)
                begin
                    r.status = STAT_WRITE_FULL;
                end
                else
                begin
                    tx_bytes.push_back(d);
                    if (line_mode == MODE_QUIET)
                    begin
                        r.line_valid = 1'b1;
                        r.line_byte  = tx_bytes.pop_front();
                        line_mode    = MODE_SENDING;
                    end
                end
            end
            KIND_READ:
            begin
                if (rx_bytes.size() == 0)
                begin
                    r.status = STAT_READ_EMPTY;
                end
                else
                begin
                    r.host_valid = 1'b1;
                    r.host_byte  = rx_bytes.pop_front();
                end
            end
            KIND_TX_READY:
            begin
                if (line_mode == MODE_SENDING)
                begin
                    if (tx_bytes.size() == 0)
                    begin
                        line_mode = MODE_QUIET;
                    end
                    else
                    begin
                        r.line_valid = 1'b1;
                        r.line_byte  = tx_bytes.pop_front();
                    end
                end
            end
            default:
            begin
                // stop wins when both characters are the same
                if (d == stop_char_q)
                begin
                    line_mode = MODE_THROTTLED;
                end
                else if (d == resume_char_q)
                begin
                    if (line_mode == MODE_THROTTLED)
                    begin
                        if (tx_bytes.size() != 0)
                        begin
                            r.line_valid = 1'b1;
                            r.line_byte  = tx_bytes.pop_front();
                            line_mode    = MODE_SENDING;
                        end
                        else
                        begin
                            line_mode = MODE_QUIET;
                        end
                    end
                end
                else if (rx_bytes.size() >= FIFO_DEPTH_DEF)
                begin
                    r.status = STAT_RX_DROP;
                end
                else
                begin
                    rx_bytes.push_back(d);
                end
            end
        endcase
        r.flow_mode = line_mode;
        return r;
    endfunction

    // sender works in bursts; valid stays high across words of a burst
    task automatic push_event(input kind_t k, input logic [7:0] d, input bit typed,
                              input result_t want);
        result_t p;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        p = channel_step(k, d);
        due_words.push_back(typed ? want : p);
        burst_left--;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_chars(input logic [7:0] stop_v, input logic [7:0] resume_v);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= REG_STOP;
        cfg_data  <= stop_v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        stop_char_q = stop_v;
        cfg_index <= REG_RESUME;
        cfg_data  <= resume_v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        resume_char_q = resume_v;
        cfg_valid <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    task automatic mixed_traffic(input int n);
        int         pick;
        int         sel;
        logic [7:0] d;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            d = 8'($urandom);
            if (pick < 30)
            begin
                push_event(KIND_WRITE, d, 1'b0, '0);
            end
            else if (pick < 50)
            begin
                push_event(KIND_READ, d, 1'b0, '0);
            end
            else if (pick < 75)
            begin
                push_event(KIND_TX_READY, d, 1'b0, '0);
            end
            else
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    d = stop_char_q;
                else if (sel == 1)
                    d = resume_char_q;
                push_event(KIND_RX, d, 1'b0, '0);
            end
        end
    endtask

    // throttle, overfill the transmit queue, resume and empty it
    task automatic fill_tx;
        push_event(KIND_RX, stop_char_q, 1'b0, '0);
        repeat (FIFO_DEPTH_DEF + 4) push_event(KIND_WRITE, 8'($urandom), 1'b0, '0);
        push_event(KIND_RX, resume_char_q, 1'b0, '0);
        repeat (FIFO_DEPTH_DEF + 4) push_event(KIND_TX_READY, 8'($urandom), 1'b0, '0);
    endtask

    // overfill the type-ahead queue with ordinary bytes, then read past empty
    task automatic fill_rx;
        logic [7:0] d;
        repeat (FIFO_DEPTH_DEF + 4)
        begin
            do
                d = 8'($urandom);
            while (d == stop_char_q || d == resume_char_q);
            push_event(KIND_RX, d, 1'b0, '0);
        end
        repeat (FIFO_DEPTH_DEF + 4) push_event(KIND_READ, 8'($urandom), 1'b0, '0);
    endtask

    // receiver stall pattern: always ready, light stalls, heavy stalls, periodic
    always @(posedge clk)
    begin
        ready_cnt <= ready_cnt + 1;
        case (ready_cnt[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= (ready_cnt[4:0] < 5'd19);
        endcase
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (due_words.size() == 0)
            begin
                $error("result word 0x%06h with nothing expected", m_tdata);
                fail_count++;
            end
            else
            begin
                want = due_words.pop_front();
                if (got.line_valid !== want.line_valid)
                begin
                    $error("line_valid: expected %0d, got %0d", want.line_valid,
                           got.line_valid);
                    fail_count++;
                end
                if (got.line_byte !== want.line_byte)
                begin
                    $error("line_byte: expected 0x%02h, got 0x%02h", want.line_byte,
                           got.line_byte);
                    fail_count++;
                end
                if (got.host_valid !== want.host_valid)
                begin
                    $error("host_valid: expected %0d, got %0d", want.host_valid,
                           got.host_valid);
                    fail_count++;
                end
                if (got.host_byte !== want.host_byte)
                begin
                    $error("host_byte: expected 0x%02h, got 0x%02h", want.host_byte,
                           got.host_byte);
                    fail_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.flow_mode !== want.flow_mode)
                begin
                    $error("flow_mode: expected %0d, got %0d", want.flow_mode,
                           got.flow_mode);
                    fail_count++;
                end
                if (got.pad !== 2'b00)
                begin
                    $error("pad: expected 0, got %0d", got.pad);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("uart_xon_xoff_fifo_channel_top verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] stop_set[6];
        logic [7:0] resume_set[6];

        // reset state, extremes of the byte, every event kind, flow transitions
        script.push_back('{KIND_READ, 8'h00, 1'b1,
                           mk_word(1'b0, 8'h00, 1'b0, 8'h00, STAT_READ_EMPTY, MODE_QUIET)});
        script.push_back('{KIND_TX_READY, 8'hff, 1'b1,
                           mk_word(1'b0, 8'h00, 1'b0, 8'h00, STAT_OK, MODE_QUIET)});
        script.push_back('{KIND_RX, RESUME_CHAR_RST, 1'b1,
                           mk_word(1'b0, 8'h00, 1'b0, 8'h00, STAT_OK, MODE_QUIET)});
        script.push_back('{KIND_WRITE, 8'h00, 1'b1,
                           mk_word(1'b1, 8'h00, 1'b0, 8'h00, STAT_OK, MODE_SENDING)});
        script.push_back('{KIND_TX_READY, 8'h00, 1'b1,
                           mk_word(1'b0, 8'h00, 1'b0, 8'h00, STAT_OK, MODE_QUIET)});
        script.push_back('{KIND_WRITE, 8'hff, 1'b1,
                           mk_word(1'b1, 8'hff, 1'b0, 8'h00, STAT_OK, MODE_SENDING)});
        script.push_back('{KIND_WRITE, 8'ha5, 1'b0, '0});
        script.push_back('{KIND_RX, STOP_CHAR_RST, 1'b0, '0});
        script.push_back('{KIND_TX_READY, 8'h5a, 1'b0, '0});
        script.push_back('{KIND_WRITE, 8'h5a, 1'b0, '0});
        script.push_back('{KIND_RX, 8'h00, 1'b0, '0});
        script.push_back('{KIND_RX, 8'hff, 1'b0, '0});
        script.push_back('{KIND_RX, STOP_CHAR_RST, 1'b0, '0});
        script.push_back('{KIND_RX, RESUME_CHAR_RST, 1'b0, '0});
        script.push_back('{KIND_RX, RESUME_CHAR_RST, 1'b0, '0});
        script.push_back('{KIND_TX_READY, 8'h00, 1'b0, '0});
        script.push_back('{KIND_TX_READY, 8'h00, 1'b0, '0});
        script.push_back('{KIND_READ, 8'hff, 1'b0, '0});
        script.push_back('{KIND_READ, 8'h00, 1'b0, '0});
        script.push_back('{KIND_READ, 8'h00, 1'b1,
                           mk_word(1'b0, 8'h00, 1'b0, 8'h00, STAT_READ_EMPTY, MODE_QUIET)});
        script.push_back('{KIND_RX, STOP_CHAR_RST, 1'b1,
                           mk_word(1'b0, 8'h00, 1'b0, 8'h00, STAT_OK, MODE_THROTTLED)});
        script.push_back('{KIND_RX, RESUME_CHAR_RST, 1'b1,
                           mk_word(1'b0, 8'h00, 1'b0, 8'h00, STAT_OK, MODE_QUIET)});

        // character settings: reset values, extremes, swapped, equal, random
        stop_set   = '{STOP_CHAR_RST, 8'h00, 8'hff, 8'h55, 8'($urandom), RESUME_CHAR_RST};
        resume_set = '{RESUME_CHAR_RST, 8'hff, 8'h00, 8'h55, 8'($urandom), STOP_CHAR_RST};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            push_event(script[i].kind, script[i].data, script[i].typed, script[i].want);

        for (int ph = 0; ph < 6; ph++)
        begin
            set_chars(stop_set[ph], resume_set[ph]);
            mixed_traffic(25);
            if (ph % 2 == 0)
                fill_tx();
            else
                fill_rx();
            mixed_traffic(20);
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("uart_xon_xoff_fifo_channel_top verification clean");
        else
            $display("uart_xon_xoff_fifo_channel_top verification failed");
        $finish;
    end

endmodule
